// ===== design/pdci_pkg.sv =====
// ----------------------------------------------------------------------------
// pdci_pkg
// Shared constants and types for the pickup/delivery cheapest-insertion block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdci_pkg;

	// Route limits
	localparam int MAX_STOPS = 16;
	localparam int MAX_LOAD  = 15;

	// Field widths
	localparam int TIME_W  = 24;
	localparam int LOAD_IN_W = 4;
	localparam int ALPHA_W = 16;
	localparam int POS_W   = 5;
	localparam int COST_W  = 48;
	localparam int STAT_W  = 2;

	// Route store geometry: one entry per stop plus the end slot
	localparam int IDX_W  = $clog2(MAX_STOPS + 1);
	localparam int LOAD_W = 6;
	localparam int ARR_W  = 29;
	localparam int PK_W   = $clog2(MAX_STOPS + 1);

	// Cost datapath widths
	localparam int COEF_W = 7;
	localparam int VAL_W  = 28;
	localparam int PROD_W = COEF_W + VAL_W;
	localparam int ACC_W  = 40;
	localparam int TOT_W  = ACC_W + ALPHA_W + 2;
	localparam int NSTEP  = 6;
	localparam int STEP_W = $clog2(NSTEP);

	// Item queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [TIME_W-1:0]  UNREACH     = '1;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd256;

	typedef enum logic [STAT_W-1:0] {
		ST_FOUND    = 2'd0,
		ST_NONE     = 2'd1,
		ST_BROKEN   = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CLS_HEADER = 2'd0,
		CLS_STOP   = 2'd1,
		CLS_END    = 2'd2
	} cls_t;

	typedef struct packed {
		cls_t                  cls;
		logic [LOAD_IN_W-1:0]  start_load;
		logic [LOAD_IN_W-1:0]  capacity;
		logic [TIME_W-1:0]     direct_time;
		logic [TIME_W-1:0]     seg_time;
		logic                  pickup_stop;
		logic [TIME_W-1:0]     pred_to_pickup;
		logic [TIME_W-1:0]     pickup_to_stop;
		logic [TIME_W-1:0]     pred_to_delivery;
		logic [TIME_W-1:0]     delivery_to_stop;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0]        leg;
		logic signed [LOAD_W-1:0] load;
		logic [ARR_W-1:0]         arr;
		logic [PK_W-1:0]          pkb;
		logic [TIME_W-1:0]        p2p;
		logic [TIME_W-1:0]        pk2s;
		logic [TIME_W-1:0]        p2d;
		logic [TIME_W-1:0]        d2s;
	} entry_t;

endpackage

`default_nettype wire

// ===== design/pdci_in_if.sv =====
// ----------------------------------------------------------------------------
// pdci_in_if
// Input item channel: header and slot items with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdci_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  start_load;
	logic [3:0]  capacity;
	logic [23:0] direct_time;
	logic [23:0] seg_time;
	logic        pickup_stop;
	logic [23:0] pred_to_pickup;
	logic [23:0] pickup_to_stop;
	logic [23:0] pred_to_delivery;
	logic [23:0] delivery_to_stop;
	logic        last;

	modport source (
		output valid, kind, start_load, capacity, direct_time, seg_time, pickup_stop,
		       pred_to_pickup, pickup_to_stop, pred_to_delivery, delivery_to_stop, last,
		input  ready
	);
	modport sink (
		input  valid, kind, start_load, capacity, direct_time, seg_time, pickup_stop,
		       pred_to_pickup, pickup_to_stop, pred_to_delivery, delivery_to_stop, last,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/pdci_out_if.sv =====
// ----------------------------------------------------------------------------
// pdci_out_if
// Result channel: status, insertion positions and cost change.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdci_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [4:0]         pickup_pos;
	logic [4:0]         delivery_pos;
	logic signed [47:0] cost_change;

	modport source (output valid, status, pickup_pos, delivery_pos, cost_change, input ready);
	modport sink   (input valid, status, pickup_pos, delivery_pos, cost_change, output ready);
endinterface

`default_nettype wire

// ===== design/pdci_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pdci_cfg_if
// Configuration write channel for the waiting cost weight.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdci_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] alpha_weight;

	modport source (output valid, alpha_weight, input ready);
	modport sink   (input valid, alpha_weight, output ready);
endinterface

`default_nettype wire

// ===== design/pdci_front.sv =====
// ----------------------------------------------------------------------------
// pdci_front
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pdci_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	pdci_in_if.sink             items,
	output logic                q_valid,
	input  wire logic           q_ready,
	output pdci_pkg::item_t     q_item
);

	pdci_pkg::item_t                 fifo_mem [pdci_pkg::QDEPTH];
	logic [pdci_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [pdci_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [pdci_pkg::QCNT_W-1:0]     count_q;
	pdci_pkg::item_t                 push_item;
	logic                            push;
	logic                            pop;

	// Classify the incoming transaction
	always_comb begin
		push_item.start_load       = items.start_load;
		push_item.capacity         = items.capacity;
		push_item.direct_time      = items.direct_time;
		push_item.seg_time         = items.seg_time;
		push_item.pickup_stop      = items.pickup_stop;
		push_item.pred_to_pickup   = items.pred_to_pickup;
		push_item.pickup_to_stop   = items.pickup_to_stop;
		push_item.pred_to_delivery = items.pred_to_delivery;
		push_item.delivery_to_stop = items.delivery_to_stop;
		if (!items.kind) begin
			push_item.cls = pdci_pkg::CLS_HEADER;
		end else if (items.last) begin
			push_item.cls = pdci_pkg::CLS_END;
		end else begin
			push_item.cls = pdci_pkg::CLS_STOP;
		end
	end

	assign items.ready = (count_q != pdci_pkg::QCNT_W'(pdci_pkg::QDEPTH));
	assign push        = items.valid && items.ready;
	assign q_valid     = (count_q != '0);
	assign pop         = q_valid && q_ready;
	assign q_item      = fifo_mem[rd_ptr_q];

	// Store queued items
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/pdci_back.sv =====
// ----------------------------------------------------------------------------
// pdci_back
// Builds the route profile from queued items and scans insertion pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module pdci_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	output logic             q_ready,
	input  pdci_pkg::item_t  q_item,
	pdci_cfg_if.sink         cfg,
	pdci_out_if.source       results
);

	localparam int LOAD_W = pdci_pkg::LOAD_W;
	localparam int COEF_W = pdci_pkg::COEF_W;
	localparam int VAL_W  = pdci_pkg::VAL_W;
	localparam int ACC_W  = pdci_pkg::ACC_W;
	localparam int TOT_W  = pdci_pkg::TOT_W;
	localparam int IDX_W  = pdci_pkg::IDX_W;
	localparam int ARR_W  = pdci_pkg::ARR_W;
	localparam int PK_W   = pdci_pkg::PK_W;
	localparam int TIME_W = pdci_pkg::TIME_W;
	localparam int COST_W = pdci_pkg::COST_W;
	localparam int ALPHA_W_L = pdci_pkg::ALPHA_W;

	localparam logic signed [LOAD_W-1:0] LOAD_ONE = 1;
	localparam logic signed [COEF_W-1:0] COEF_ONE = 1;
	localparam logic [pdci_pkg::STEP_W-1:0] STEP_LAST = pdci_pkg::STEP_W'(pdci_pkg::NSTEP - 1);
	localparam int STEP_TRAVEL = 4;

	typedef enum logic [3:0] {
		S_IDLE, S_PP_RD, S_PP_LAT, S_PD_RD, S_PD_CHK, S_MAC, S_ALPHA, S_CMP, S_DONE
	} state_t;

	function automatic logic [3:0] clamp_load(input logic [3:0] v);
		return (v > 4'(pdci_pkg::MAX_LOAD)) ? 4'(pdci_pkg::MAX_LOAD) : v;
	endfunction

	function automatic logic signed [VAL_W-1:0] tv(input logic [TIME_W-1:0] t);
		return signed'(VAL_W'(t));
	endfunction

	function automatic logic signed [COEF_W-1:0] pdiff(input logic [PK_W-1:0] a,
		input logic [PK_W-1:0] b);
		return signed'(COEF_W'(a)) - signed'(COEF_W'(b));
	endfunction

	state_t                         state_q;
	logic [ALPHA_W_L-1:0]           alpha_q;

	// Header and route bookkeeping
	logic [3:0]                     hdr_l0_q;
	logic [3:0]                     hdr_cap_q;
	logic [TIME_W-1:0]              hdr_direct_q;
	logic [IDX_W-1:0]               cnt_q;
	logic                           broken_q;
	logic                           ovf_q;
	logic signed [LOAD_W-1:0]       last_load_q;
	logic [ARR_W-1:0]               arr_run_q;
	logic [PK_W-1:0]                pk_cnt_q;

	// Route store
	pdci_pkg::entry_t               mem [pdci_pkg::MAX_STOPS + 1];
	pdci_pkg::entry_t               rd_a_q;
	pdci_pkg::entry_t               rd_b_q;
	pdci_pkg::entry_t               wr_data;
	logic                           wr_en;
	logic [IDX_W-1:0]               rd_addr_a;
	logic [IDX_W-1:0]               rd_addr_b;

	// Scan registers
	logic [IDX_W-1:0]               n_q;
	logic [IDX_W-1:0]               pp_q;
	logic [IDX_W-1:0]               pd_q;
	logic [PK_W-1:0]                tot_pk_q;
	logic signed [LOAD_W-1:0]       lbp_q;
	logic [TIME_W-1:0]              stp_q;
	logic [TIME_W-1:0]              spo_q;
	logic [TIME_W-1:0]              tsp_q;
	logic [TIME_W-1:0]              sdo_pp_q;
	logic [ARR_W-1:0]               arr_pp_q;
	logic [ARR_W-1:0]               arr_p_q;
	logic [PK_W-1:0]                pkb_pp_q;
	logic signed [COEF_W-1:0]       coef_q [pdci_pkg::NSTEP];
	logic signed [VAL_W-1:0]        val_q  [pdci_pkg::NSTEP];
	logic [pdci_pkg::STEP_W-1:0]    step_q;
	logic signed [ACC_W-1:0]        t_acc_q;
	logic signed [ACC_W-1:0]        w_acc_q;
	logic signed [TOT_W-1:0]        tot_q;
	logic signed [TOT_W-1:0]        best_q;
	logic [IDX_W-1:0]               best_pp_q;
	logic [IDX_W-1:0]               best_pd_q;
	logic                           found_q;
	pdci_pkg::status_t              pend_status_q;

	// Result register
	logic                           res_vld_q;
	pdci_pkg::status_t              res_status_q;
	logic [pdci_pkg::POS_W-1:0]     res_pp_q;
	logic [pdci_pkg::POS_W-1:0]     res_pd_q;
	logic signed [COST_W-1:0]       res_cost_q;

	// Combinational helpers
	logic signed [LOAD_W-1:0]       l0_s;
	logic signed [COEF_W-1:0]       cap_s;
	logic signed [LOAD_W-1:0]       lb_c;
	logic [ARR_W-1:0]               ab_c;
	logic [PK_W-1:0]                pkb_now_c;
	logic signed [LOAD_W-1:0]       lbp_c;
	logic signed [COEF_W-1:0]       lbp1_c;
	logic [ARR_W-1:0]               arr_p_c;
	logic                           pp_skip_c;
	logic                           pd_brk_c;
	logic                           pd_skip_c;
	logic signed [COEF_W-1:0]       coef_c [pdci_pkg::NSTEP];
	logic signed [VAL_W-1:0]        val_c  [pdci_pkg::NSTEP];
	logic signed [ACC_W-1:0]        tbase_c;
	logic signed [pdci_pkg::PROD_W-1:0] prod_c;
	logic signed [TOT_W-1:0]        aw_c;
	logic signed [TOT_W-1:0]        tot_c;
	logic signed [TOT_W-1:0]        rsum_c;
	logic signed [ALPHA_W_L:0]      alpha_s;
	logic                           res_load;

	assign l0_s  = signed'(LOAD_W'(clamp_load(hdr_l0_q)));
	assign cap_s = signed'(COEF_W'(clamp_load(hdr_cap_q)));

	assign q_ready   = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// Profile update for a stop slot
	always_comb begin
		lb_c      = (cnt_q == '0) ? l0_s : last_load_q;
		ab_c      = (cnt_q == '0) ? '0 : arr_run_q;
		pkb_now_c = (cnt_q == '0) ? '0 : pk_cnt_q;
		wr_data.leg  = q_item.seg_time;
		wr_data.load = q_item.pickup_stop ? lb_c + LOAD_ONE : lb_c - LOAD_ONE;
		wr_data.arr  = ab_c + ARR_W'(q_item.seg_time);
		wr_data.pkb  = pkb_now_c;
		wr_data.p2p  = q_item.pred_to_pickup;
		wr_data.pk2s = q_item.pickup_to_stop;
		wr_data.p2d  = q_item.pred_to_delivery;
		wr_data.d2s  = q_item.delivery_to_stop;
		wr_en = 1'b0;
		if (state_q == S_IDLE && q_valid && !ovf_q) begin
			if (q_item.cls == pdci_pkg::CLS_END) begin
				wr_en = 1'b1;
			end else if (q_item.cls == pdci_pkg::CLS_STOP &&
				cnt_q < IDX_W'(pdci_pkg::MAX_STOPS)) begin
				wr_en = 1'b1;
			end
		end
	end

	// Read pickup position entries in the outer phase, delivery ones in the inner phase
	assign rd_addr_a = (state_q == S_PP_RD || state_q == S_PP_LAT) ? pp_q : pd_q;
	assign rd_addr_b = (rd_addr_a == '0) ? '0 : rd_addr_a - 1'b1;

	// Route store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q] <= wr_data;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	// Pickup position terms
	always_comb begin
		lbp_c     = (pp_q == '0) ? l0_s : rd_b_q.load;
		lbp1_c    = COEF_W'(lbp_c) + COEF_ONE;
		arr_p_c   = ((pp_q == '0) ? '0 : rd_b_q.arr) + ARR_W'(rd_a_q.p2p);
		pp_skip_c = (lbp1_c > cap_s) || (rd_a_q.p2p == pdci_pkg::UNREACH);
	end

	// Pair operands: four travel products, two waiting products
	always_comb begin
		logic signed [COEF_W-1:0] lbp1, lbp2, lbd1, lbd2;
		logic signed [VAL_W-1:0]  dp, dd;
		logic                     same, at_end;
		lbp1   = COEF_W'(lbp_q) + COEF_ONE;
		lbp2   = lbp1 + COEF_ONE;
		lbd1   = COEF_W'(rd_b_q.load) + COEF_ONE;
		lbd2   = lbd1 + COEF_ONE;
		same   = (pd_q == pp_q);
		at_end = (pd_q == n_q);
		dp     = tv(stp_q) + tv(spo_q) - tv(tsp_q);
		dd     = at_end ? tv(rd_a_q.p2d)
		                : tv(rd_a_q.p2d) + tv(rd_a_q.d2s) - tv(rd_a_q.leg);
		pd_brk_c  = !same && (lbd1 > cap_s);
		pd_skip_c = 1'b0;
		tbase_c   = '0;
		for (int i = 0; i < pdci_pkg::NSTEP; i++) begin
			coef_c[i] = '0;
			val_c[i]  = '0;
		end
		if (same && !at_end) begin
			pd_skip_c = (sdo_pp_q == pdci_pkg::UNREACH);
			coef_c[0] = lbp1;
			val_c[0]  = tv(stp_q) - tv(tsp_q) + tv(sdo_pp_q);
			coef_c[1] = lbp2;
			val_c[1]  = tv(hdr_direct_q);
			coef_c[4] = pdiff(tot_pk_q, pkb_pp_q);
			val_c[4]  = tv(stp_q) + tv(hdr_direct_q) + tv(sdo_pp_q) - tv(tsp_q);
		end else if (same) begin
			coef_c[0] = lbp1;
			val_c[0]  = tv(stp_q);
			coef_c[1] = lbp2;
			val_c[1]  = tv(hdr_direct_q);
		end else begin
			pd_skip_c = (spo_q == pdci_pkg::UNREACH) ||
				(rd_a_q.p2d == pdci_pkg::UNREACH) ||
				(!at_end && rd_a_q.d2s == pdci_pkg::UNREACH);
			coef_c[0] = lbp1;
			val_c[0]  = tv(stp_q) - tv(tsp_q);
			coef_c[1] = lbp2;
			val_c[1]  = tv(spo_q);
			coef_c[2] = at_end ? '0 : lbd1;
			val_c[2]  = tv(rd_a_q.d2s) - tv(rd_a_q.leg);
			coef_c[3] = lbd2;
			val_c[3]  = tv(rd_a_q.p2d);
			tbase_c   = signed'(ACC_W'(rd_b_q.arr)) - signed'(ACC_W'(arr_pp_q));
			coef_c[4] = pdiff(rd_a_q.pkb, pkb_pp_q);
			val_c[4]  = dp;
			coef_c[5] = pdiff(tot_pk_q, rd_a_q.pkb);
			val_c[5]  = dp + dd;
		end
	end

	// Shared multiply-accumulate, alpha weighting, rounding
	assign prod_c  = coef_q[step_q] * val_q[step_q];
	assign alpha_s = signed'({1'b0, alpha_q});
	assign aw_c    = alpha_s * w_acc_q;
	assign tot_c   = (TOT_W'(t_acc_q) <<< 8) + aw_c;
	assign rsum_c  = best_q + TOT_W'(128);
	assign res_load = (state_q == S_DONE) && (!res_vld_q || results.ready);

	assign results.valid        = res_vld_q;
	assign results.status       = res_status_q;
	assign results.pickup_pos   = res_pp_q;
	assign results.delivery_pos = res_pd_q;
	assign results.cost_change  = res_cost_q;

	// Sequencer: route building, pair scan and result hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			alpha_q       <= pdci_pkg::ALPHA_RESET;
			hdr_l0_q      <= '0;
			hdr_cap_q     <= '0;
			hdr_direct_q  <= '0;
			cnt_q         <= '0;
			broken_q      <= 1'b0;
			ovf_q         <= 1'b0;
			last_load_q   <= '0;
			arr_run_q     <= '0;
			pk_cnt_q      <= '0;
			n_q           <= '0;
			pp_q          <= '0;
			pd_q          <= '0;
			tot_pk_q      <= '0;
			lbp_q         <= '0;
			stp_q         <= '0;
			spo_q         <= '0;
			tsp_q         <= '0;
			sdo_pp_q      <= '0;
			arr_pp_q      <= '0;
			arr_p_q       <= '0;
			pkb_pp_q      <= '0;
			for (int i = 0; i < pdci_pkg::NSTEP; i++) begin
				coef_q[i] <= '0;
				val_q[i]  <= '0;
			end
			step_q        <= '0;
			t_acc_q       <= '0;
			w_acc_q       <= '0;
			tot_q         <= '0;
			best_q        <= '0;
			best_pp_q     <= '0;
			best_pd_q     <= '0;
			found_q       <= 1'b0;
			pend_status_q <= pdci_pkg::ST_FOUND;
			res_vld_q     <= 1'b0;
			res_status_q  <= pdci_pkg::ST_FOUND;
			res_pp_q      <= '0;
			res_pd_q      <= '0;
			res_cost_q    <= '0;
		end else begin
			if (cfg.valid) begin
				alpha_q <= cfg.alpha_weight;
			end
			if (results.valid && results.ready && !res_load) begin
				res_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						case (q_item.cls)
							pdci_pkg::CLS_HEADER: begin
								hdr_l0_q     <= q_item.start_load;
								hdr_cap_q    <= q_item.capacity;
								hdr_direct_q <= q_item.direct_time;
								cnt_q        <= '0;
								broken_q     <= 1'b0;
								ovf_q        <= 1'b0;
							end
							pdci_pkg::CLS_STOP: begin
								if (!wr_en) begin
									ovf_q <= 1'b1;
								end else begin
									cnt_q       <= cnt_q + 1'b1;
									last_load_q <= wr_data.load;
									arr_run_q   <= wr_data.arr;
									pk_cnt_q    <= pkb_now_c + PK_W'(q_item.pickup_stop);
									if (q_item.seg_time == pdci_pkg::UNREACH) begin
										broken_q <= 1'b1;
									end
								end
							end
							pdci_pkg::CLS_END: begin
								cnt_q    <= '0;
								broken_q <= 1'b0;
								ovf_q    <= 1'b0;
								n_q      <= cnt_q;
								tot_pk_q <= pkb_now_c;
								pp_q     <= '0;
								found_q  <= 1'b0;
								state_q  <= S_DONE;
								if (ovf_q) begin
									pend_status_q <= pdci_pkg::ST_OVERFLOW;
								end else if (broken_q ||
									clamp_load(hdr_l0_q) > clamp_load(hdr_cap_q)) begin
									pend_status_q <= pdci_pkg::ST_BROKEN;
								end else if (hdr_direct_q == pdci_pkg::UNREACH) begin
									pend_status_q <= pdci_pkg::ST_NONE;
								end else begin
									pend_status_q <= pdci_pkg::ST_FOUND;
									state_q       <= S_PP_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_PP_RD: begin
					state_q <= S_PP_LAT;
				end
				S_PP_LAT: begin
					lbp_q    <= lbp_c;
					stp_q    <= rd_a_q.p2p;
					spo_q    <= rd_a_q.pk2s;
					tsp_q    <= rd_a_q.leg;
					sdo_pp_q <= rd_a_q.d2s;
					arr_pp_q <= rd_a_q.arr;
					arr_p_q  <= arr_p_c;
					pkb_pp_q <= rd_a_q.pkb;
					pd_q     <= pp_q;
					if (!pp_skip_c) begin
						state_q <= S_PD_RD;
					end else if (pp_q == n_q) begin
						state_q <= S_DONE;
					end else begin
						pp_q    <= pp_q + 1'b1;
						state_q <= S_PP_RD;
					end
				end
				S_PD_RD: begin
					state_q <= S_PD_CHK;
				end
				S_PD_CHK: begin
					for (int i = 0; i < pdci_pkg::NSTEP; i++) begin
						coef_q[i] <= coef_c[i];
						val_q[i]  <= val_c[i];
					end
					t_acc_q <= tbase_c;
					w_acc_q <= signed'(ACC_W'(arr_p_q));
					step_q  <= '0;
					if (pd_brk_c || (pd_skip_c && pd_q == n_q)) begin
						// Leave this pickup position
						if (pp_q == n_q) begin
							state_q <= S_DONE;
						end else begin
							pp_q    <= pp_q + 1'b1;
							state_q <= S_PP_RD;
						end
					end else if (pd_skip_c) begin
						pd_q    <= pd_q + 1'b1;
						state_q <= S_PD_RD;
					end else begin
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (step_q < pdci_pkg::STEP_W'(STEP_TRAVEL)) begin
						t_acc_q <= t_acc_q + ACC_W'(prod_c);
					end else begin
						w_acc_q <= w_acc_q + ACC_W'(prod_c);
					end
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= S_ALPHA;
					end
				end
				S_ALPHA: begin
					tot_q   <= tot_c;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// Strictly smaller wins: the first pair keeps ties
					if (!found_q || tot_q < best_q) begin
						found_q   <= 1'b1;
						best_q    <= tot_q;
						best_pp_q <= pp_q;
						best_pd_q <= pd_q;
					end
					if (pd_q != n_q) begin
						pd_q    <= pd_q + 1'b1;
						state_q <= S_PD_RD;
					end else if (pp_q != n_q) begin
						pp_q    <= pp_q + 1'b1;
						state_q <= S_PP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						res_vld_q <= 1'b1;
						state_q   <= S_IDLE;
						if (pend_status_q == pdci_pkg::ST_FOUND && found_q) begin
							res_status_q <= pdci_pkg::ST_FOUND;
							res_pp_q     <= pdci_pkg::POS_W'(best_pp_q);
							res_pd_q     <= pdci_pkg::POS_W'(best_pd_q);
							res_cost_q   <= rsum_c[COST_W+7:8];
						end else begin
							res_status_q <= (pend_status_q == pdci_pkg::ST_FOUND) ?
								pdci_pkg::ST_NONE : pend_status_q;
							res_pp_q     <= '0;
							res_pd_q     <= '0;
							res_cost_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/pickup_delivery_cheapest_insertion.sv =====
// The back end takes header and stop slots from the queue in its idle state.
// An end slot with n stops runs a pair scan over at most (n+1)(n+2)/2 pairs
// (pickup, delivery), each through the single shared multiply-accumulate unit;
// the result then waits in its register.
// A 4-entry input queue accepts items until full while the scan or result stalls.
// Reset clears control state; the route store is undefined until written.
// ----------------------------------------------------------------------------
// pickup_delivery_cheapest_insertion
// Top level: front queue, back-end route builder and cheapest-pair scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module pickup_delivery_cheapest_insertion (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pdci_in_if.sink     items,
	pdci_out_if.source  results,
	pdci_cfg_if.sink    cfg
);

	logic             q_valid;
	logic             q_ready;
	pdci_pkg::item_t  q_item;

	pdci_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	pdci_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.cfg     (cfg),
		.results (results)
	);

`ifndef SYNTHESIS
	// A failed search reports no positions and no cost
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status != pdci_pkg::ST_FOUND |->
		results.pickup_pos == '0 && results.delivery_pos == '0 && results.cost_change == '0)
		else $error("non-found result carries payload");

	// The delivery never goes before the pickup
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status == pdci_pkg::ST_FOUND |->
		results.pickup_pos <= results.delivery_pos)
		else $error("delivery position before pickup position");

	// Positions stay within the stop limit
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.delivery_pos <= 5'(pdci_pkg::MAX_STOPS))
		else $error("position beyond stop limit");
`endif

endmodule

`default_nettype wire
